/* hw/rtl/hrbp_pkg.sv */
// shared types and constants of the http request byte parser
package hrbp_pkg;

	// character codes seen by the tokenizer
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// length of the content-length key text
	localparam logic [3:0] CL_LEN = 4'd14;

	// input beat as held in the input register
	typedef struct packed {
		logic [7:0] data_byte;
		logic       new_connection;
	} in_beat_t;

	// result beat as held in the result register
	typedef struct packed {
		logic [7:0]  out_byte;
		logic [2:0]  byte_class;
		logic        header_complete;
		logic        headers_end;
		logic        request_done;
		logic        length_error;
		logic [31:0] body_length;
	} result_t;

	// characters of the content-length key
	function automatic logic [7:0] cl_char(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0:    ch = 8'h43; // C
			4'd1:    ch = 8'h6F; // o
			4'd2:    ch = 8'h6E; // n
			4'd3:    ch = 8'h74; // t
			4'd4:    ch = 8'h65; // e
			4'd5:    ch = 8'h6E; // n
			4'd6:    ch = 8'h74; // t
			4'd7:    ch = 8'h2D; // -
			4'd8:    ch = 8'h4C; // L
			4'd9:    ch = 8'h65; // e
			4'd10:   ch = 8'h6E; // n
			4'd11:   ch = 8'h67; // g
			4'd12:   ch = 8'h74; // t
			4'd13:   ch = 8'h68; // h
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

/* hw/rtl/hrbp_if.sv */
// byte input and tagged result channel interfaces
interface hrbp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       new_connection;

	modport source (output valid, output data_byte, output new_connection, input ready);
	modport sink (input valid, input data_byte, input new_connection, output ready);
endinterface

interface hrbp_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic [2:0]  byte_class;
	logic        header_complete;
	logic        headers_end;
	logic        request_done;
	logic        length_error;
	logic [31:0] body_length;

	modport source (
		output valid, output out_byte, output byte_class, output header_complete,
		output headers_end, output request_done, output length_error, output body_length,
		input ready
	);
	modport sink (
		input valid, input out_byte, input byte_class, input header_complete,
		input headers_end, input request_done, input length_error, input body_length,
		output ready
	);
endinterface

/* hw/rtl/http_request_byte_parser_core.sv */
// http request byte parser: an accepted beat passes the input register, then the result register
// throughput one byte per cycle while the result sink is ready, limited by the single parser state update
// the input register and the result register each hold one beat under stall
// reset puts the parser in the method phase with an empty line and zero lengths
// a set new_connection bit restarts the parser before its own byte
module http_request_byte_parser_core import hrbp_pkg::*; #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	hrbp_in_if.sink    in_ch,
	hrbp_out_if.source out_ch
);

	logic     valid_s1;
	in_beat_t beat_s1;
	logic     advance;
	result_t  result;

	// input register
	hrbp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	// parser state and classification
	hrbp_tokenizer #(
		.LENGTH_WIDTH (LENGTH_WIDTH)
	) u_tokenizer (
		.clk     (clk),
		.arst_n  (arst_n),
		.beat    (beat_s1),
		.advance (advance),
		.result  (result)
	);

	// result register
	hrbp_out_stage u_out_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.result   (result),
		.advance  (advance),
		.out_ch   (out_ch)
	);

endmodule

/* hw/rtl/hrbp_in_stage.sv */
// input register stage of the http request byte parser
module hrbp_in_stage import hrbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	hrbp_in_if.sink   in_ch,
	input  logic      advance,
	output logic      valid_s1,
	output in_beat_t  beat_s1
);

	logic accept;

	// register is free when empty or when its beat moves on this cycle
	assign in_ch.ready = !valid_s1 || advance;
	assign accept = in_ch.valid && in_ch.ready;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.data_byte      <= in_ch.data_byte;
			beat_s1.new_connection <= in_ch.new_connection;
		end
	end

endmodule

/* hw/rtl/hrbp_tokenizer.sv */
// parser state and per-byte classification logic
module hrbp_tokenizer import hrbp_pkg::*; #(
	parameter int LENGTH_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  in_beat_t beat,
	input  logic     advance,
	output result_t  result
);

	localparam int LW = LENGTH_WIDTH;
	localparam int SW = (LW > 32) ? LW : 32;
	localparam logic [LW-1:0] LEN_MAX = '1;

	// parse phases
	localparam logic [2:0] PH_METHOD  = 3'd0;
	localparam logic [2:0] PH_PATH    = 3'd1;
	localparam logic [2:0] PH_VERSION = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_VALUE   = 3'd4;
	localparam logic [2:0] PH_BODY    = 3'd5;

	// byte classes
	localparam logic [2:0] CL_DROP    = 3'd0;
	localparam logic [2:0] CL_METHOD  = 3'd1;
	localparam logic [2:0] CL_PATH    = 3'd2;
	localparam logic [2:0] CL_VERSION = 3'd3;
	localparam logic [2:0] CL_KEY     = 3'd4;
	localparam logic [2:0] CL_VALUE   = 3'd5;
	localparam logic [2:0] CL_BODY    = 3'd6;

	// digit scan status
	localparam logic [1:0] DV_NONE = 2'd0;
	localparam logic [1:0] DV_IN   = 2'd1;
	localparam logic [1:0] DV_END  = 2'd2;
	localparam logic [1:0] DV_ERR  = 2'd3;

	logic [2:0]    phase_q, cur_phase, nxt_phase;
	logic          key_ne_q, cur_key_ne, nxt_key_ne;
	logic          val_ne_q, cur_val_ne, nxt_val_ne;
	logic [3:0]    match_pos_q, cur_match_pos, nxt_match_pos;
	logic          match_alive_q, cur_match_alive, nxt_match_alive;
	logic [LW-1:0] acc_q, cur_acc, nxt_acc;
	logic [1:0]    dv_q, cur_dv, nxt_dv;
	logic [LW-1:0] len_q, cur_len, nxt_len;
	logic [LW-1:0] body_q, cur_body, nxt_body;

	logic [7:0]    c;
	logic          is_digit;
	logic [LW+3:0] acc_x10;
	logic          acc_ovf;
	logic [LW-1:0] body_step;
	logic [SW-1:0] len_ext;
	logic [2:0]    cls;
	logic          hc, he, done, lerr;
	logic [31:0]   shown;

	assign c        = beat.data_byte;
	assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);

	// accumulator times ten plus digit, overflow when it leaves the length width
	assign acc_x10 = (LW+4)'({cur_acc, 3'b000}) + (LW+4)'({cur_acc, 1'b0})
		+ (LW+4)'(c[3:0]);
	assign acc_ovf = |acc_x10[LW+3:LW];

	// saturating body counter step
	assign body_step = (cur_body != LEN_MAX) ? (cur_body + LW'(1)) : cur_body;

	// next state and result for the byte in the input register
	always_comb begin
		// a new connection starts from reset state
		if (beat.new_connection) begin
			cur_phase       = PH_METHOD;
			cur_key_ne      = 1'b0;
			cur_val_ne      = 1'b0;
			cur_match_pos   = 4'd0;
			cur_match_alive = 1'b1;
			cur_acc         = '0;
			cur_dv          = DV_NONE;
			cur_len         = '0;
			cur_body        = '0;
		end else begin
			cur_phase       = phase_q;
			cur_key_ne      = key_ne_q;
			cur_val_ne      = val_ne_q;
			cur_match_pos   = match_pos_q;
			cur_match_alive = match_alive_q;
			cur_acc         = acc_q;
			cur_dv          = dv_q;
			cur_len         = len_q;
			cur_body        = body_q;
		end

		nxt_phase       = cur_phase;
		nxt_key_ne      = cur_key_ne;
		nxt_val_ne      = cur_val_ne;
		nxt_match_pos   = cur_match_pos;
		nxt_match_alive = cur_match_alive;
		nxt_acc         = cur_acc;
		nxt_dv          = cur_dv;
		nxt_len         = cur_len;
		nxt_body        = cur_body;
		cls  = CL_DROP;
		hc   = 1'b0;
		he   = 1'b0;
		done = 1'b0;
		lerr = 1'b0;

		case (cur_phase)
			PH_METHOD: begin
				if (c == CH_SPACE) nxt_phase = PH_PATH;
				else cls = CL_METHOD;
			end
			PH_PATH: begin
				if (c == CH_SPACE) nxt_phase = PH_VERSION;
				else cls = CL_PATH;
			end
			PH_VERSION: begin
				if (c != CH_CR) begin
					if (c == CH_LF) begin
						nxt_phase       = PH_KEY;
						nxt_key_ne      = 1'b0;
						nxt_val_ne      = 1'b0;
						nxt_match_pos   = 4'd0;
						nxt_match_alive = 1'b1;
						nxt_acc         = '0;
						nxt_dv          = DV_NONE;
					end else begin
						cls = CL_VERSION;
					end
				end
			end
			PH_KEY: begin
				if (c != CH_CR) begin
					if (c == CH_LF) begin
						// empty line closes the headers
						if (!cur_key_ne) begin
							he = 1'b1;
							if (cur_len != '0) nxt_phase = PH_BODY;
							else done = 1'b1;
						end
						nxt_key_ne      = 1'b0;
						nxt_val_ne      = 1'b0;
						nxt_match_pos   = 4'd0;
						nxt_match_alive = 1'b1;
						nxt_acc         = '0;
						nxt_dv          = DV_NONE;
					end else if (c == CH_COLON) begin
						nxt_phase = PH_VALUE;
					end else begin
						cls        = CL_KEY;
						nxt_key_ne = 1'b1;
						if (cur_match_alive && (cur_match_pos < CL_LEN)
							&& (c == cl_char(cur_match_pos))) begin
							nxt_match_pos = cur_match_pos + 4'd1;
						end else begin
							nxt_match_alive = 1'b0;
						end
					end
				end
			end
			PH_VALUE: begin
				if (c != CH_CR) begin
					if (c == CH_LF) begin
						hc = 1'b1;
						// content-length line loads the body length
						if (cur_match_alive && (cur_match_pos == CL_LEN)) begin
							nxt_len = cur_acc;
							if ((cur_dv == DV_NONE) || (cur_dv == DV_ERR)) lerr = 1'b1;
						end
						nxt_phase       = PH_KEY;
						nxt_key_ne      = 1'b0;
						nxt_val_ne      = 1'b0;
						nxt_match_pos   = 4'd0;
						nxt_match_alive = 1'b1;
						nxt_acc         = '0;
						nxt_dv          = DV_NONE;
					end else if (cur_val_ne || (c != CH_SPACE)) begin
						cls        = CL_VALUE;
						nxt_val_ne = 1'b1;
						if ((cur_dv == DV_NONE) || (cur_dv == DV_IN)) begin
							if (is_digit) begin
								if (acc_ovf) begin
									nxt_acc = LEN_MAX;
									nxt_dv  = DV_ERR;
								end else begin
									nxt_acc = acc_x10[LW-1:0];
									nxt_dv  = DV_IN;
								end
							end else begin
								nxt_dv = (cur_dv == DV_NONE) ? DV_ERR : DV_END;
							end
						end
					end
				end
			end
			PH_BODY: begin
				cls      = CL_BODY;
				nxt_body = body_step;
				if (body_step >= cur_len) done = 1'b1;
			end
			default: begin
				if (c != CH_SPACE) begin
					nxt_phase = PH_METHOD;
					cls       = CL_METHOD;
				end else begin
					nxt_phase = PH_PATH;
				end
			end
		endcase

		// length shown before any restart, capped to the port width
		len_ext = SW'(nxt_len);
		if (len_ext > SW'(32'hFFFF_FFFF)) shown = 32'hFFFF_FFFF;
		else shown = len_ext[31:0];

		// completed request restarts the parser
		if (done) begin
			nxt_phase       = PH_METHOD;
			nxt_key_ne      = 1'b0;
			nxt_val_ne      = 1'b0;
			nxt_match_pos   = 4'd0;
			nxt_match_alive = 1'b1;
			nxt_acc         = '0;
			nxt_dv          = DV_NONE;
			nxt_len         = '0;
			nxt_body        = '0;
		end
	end

	// result beat
	always_comb begin
		result.out_byte        = c;
		result.byte_class      = cls;
		result.header_complete = hc;
		result.headers_end     = he;
		result.request_done    = done;
		result.length_error    = lerr;
		result.body_length     = shown;
	end

	// parser state update when the beat moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_METHOD;
			key_ne_q      <= 1'b0;
			val_ne_q      <= 1'b0;
			match_pos_q   <= 4'd0;
			match_alive_q <= 1'b1;
			acc_q         <= '0;
			dv_q          <= DV_NONE;
			len_q         <= '0;
			body_q        <= '0;
		end else if (advance) begin
			phase_q       <= nxt_phase;
			key_ne_q      <= nxt_key_ne;
			val_ne_q      <= nxt_val_ne;
			match_pos_q   <= nxt_match_pos;
			match_alive_q <= nxt_match_alive;
			acc_q         <= nxt_acc;
			dv_q          <= nxt_dv;
			len_q         <= nxt_len;
			body_q        <= nxt_body;
		end
	end

endmodule

/* hw/rtl/hrbp_out_stage.sv */
// result register stage of the http request byte parser
module hrbp_out_stage import hrbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  result_t   result,
	output logic      advance,
	hrbp_out_if.source out_ch
);

	logic    valid_s2;
	result_t result_s2;

	// a beat moves in when the register is empty or being drained
	assign advance = valid_s1 && (!valid_s2 || out_ch.ready);

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	// payload capture
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	// output channel
	assign out_ch.valid           = valid_s2;
	assign out_ch.out_byte        = result_s2.out_byte;
	assign out_ch.byte_class      = result_s2.byte_class;
	assign out_ch.header_complete = result_s2.header_complete;
	assign out_ch.headers_end     = result_s2.headers_end;
	assign out_ch.request_done    = result_s2.request_done;
	assign out_ch.length_error    = result_s2.length_error;
	assign out_ch.body_length     = result_s2.body_length;

endmodule

/* tb/hrbp_tag_check.sv */
// byte tag predictor and result comparison for the http request byte parser
module hrbp_tag_check import hrbp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	hrbp_in_if   in_ch,
	hrbp_out_if  out_ch,
	output int   mismatches,
	output int   pending
);

	typedef enum logic [2:0] {
		ST_METHOD, ST_PATH, ST_VERSION, ST_KEY, ST_VALUE, ST_BODY
	} parse_phase_t;

	typedef enum logic [2:0] {
		TAG_DROP, TAG_METHOD, TAG_PATH, TAG_VERSION, TAG_KEY, TAG_VALUE, TAG_BODY
	} byte_tag_t;

	typedef enum logic [1:0] {DG_NONE, DG_IN, DG_END, DG_BAD} digit_state_t;

	localparam logic [63:0]     LEN_MAX     = 64'h0000_0000_FFFF_FFFF;
	localparam logic [8*14-1:0] CL_KEY_TEXT = "Content-Length";

	// parser state as the block should hold it
	parse_phase_t ph;
	logic         key_seen;
	logic         val_seen;
	logic [3:0]   match_pos;
	logic         match_ok;
	logic [63:0]  acc;
	digit_state_t dig;
	logic [63:0]  content_len;
	logic [63:0]  body_cnt;

	result_t expected_tags[$];
	int      fails   = 0;
	int      waiting = 0;

	assign mismatches = fails;
	assign pending    = waiting;

	function automatic void clear_line();
		key_seen  = 1'b0;
		val_seen  = 1'b0;
		match_pos = '0;
		match_ok  = 1'b1;
		acc       = '0;
		dig       = DG_NONE;
	endfunction

	function automatic void restart();
		ph = ST_METHOD;
		clear_line();
		content_len = '0;
		body_cnt    = '0;
	endfunction

	// tag one byte and advance the parser state
	function automatic result_t tag_byte(input logic [7:0] c, input logic nc);
		result_t     r;
		byte_tag_t   cls;
		logic [63:0] d;
		logic        finish;
		r      = '0;
		cls    = TAG_DROP;
		finish = 1'b0;
		if (nc)
			restart();
		case (ph)
			ST_METHOD: begin
				if (c == CH_SPACE) ph = ST_PATH;
				else cls = TAG_METHOD;
			end
			ST_PATH: begin
				if (c == CH_SPACE) ph = ST_VERSION;
				else cls = TAG_PATH;
			end
			ST_VERSION: begin
				if (c == CH_LF) begin
					ph = ST_KEY;
					clear_line();
				end else if (c != CH_CR) begin
					cls = TAG_VERSION;
				end
			end
			ST_KEY: begin
				if (c == CH_LF) begin
					// empty line closes the headers, a key with no colon is thrown away
					if (!key_seen) begin
						r.headers_end = 1'b1;
						if (content_len > 0) ph = ST_BODY;
						else finish = 1'b1;
					end
					clear_line();
				end else if (c == CH_COLON) begin
					ph = ST_VALUE;
				end else if (c != CH_CR) begin
					cls      = TAG_KEY;
					key_seen = 1'b1;
					if (match_ok && match_pos < CL_LEN &&
						c == CL_KEY_TEXT[8*(13 - int'(match_pos)) +: 8])
						match_pos++;
					else
						match_ok = 1'b0;
				end
			end
			ST_VALUE: begin
				if (c == CH_LF) begin
					r.header_complete = 1'b1;
					if (match_ok && match_pos == CL_LEN) begin
						content_len = acc & LEN_MAX;
						if (dig == DG_NONE || dig == DG_BAD)
							r.length_error = 1'b1;
					end
					clear_line();
					ph = ST_KEY;
				end else if (c != CH_CR && !(!val_seen && c == CH_SPACE)) begin
					cls      = TAG_VALUE;
					val_seen = 1'b1;
					// leading digits build the length, saturating on overflow
					if (dig == DG_NONE || dig == DG_IN) begin
						if (c >= CH_ZERO && c <= CH_NINE) begin
							d = 64'(c - CH_ZERO);
							if (acc > (LEN_MAX - d) / 10) begin
								acc = LEN_MAX;
								dig = DG_BAD;
							end else begin
								acc = acc * 10 + d;
								dig = DG_IN;
							end
						end else begin
							dig = (dig == DG_NONE) ? DG_BAD : DG_END;
						end
					end
				end
			end
			ST_BODY: begin
				cls = TAG_BODY;
				if (body_cnt < LEN_MAX)
					body_cnt++;
				if (body_cnt >= content_len)
					finish = 1'b1;
			end
			default: begin
				ph = ST_METHOD;
				if (c != CH_SPACE) cls = TAG_METHOD;
				else ph = ST_PATH;
			end
		endcase
		r.out_byte     = c;
		r.byte_class   = cls;
		r.request_done = finish;
		r.body_length  = content_len[31:0];
		if (finish)
			restart();
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$error("%s expected %0h got %0h", name, want, got);
			fails++;
		end
	endfunction

	// results are compared before the same edge's input beat is predicted
	always @(posedge clk or negedge arst_n) begin : watch
		result_t want;
		if (!arst_n) begin
			restart();
			expected_tags.delete();
			waiting = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_tags.size() == 0) begin
					$error("result beat with no byte waiting for it");
					fails++;
				end else begin
					want = expected_tags.pop_front();
					check_field("out_byte", want.out_byte, out_ch.out_byte);
					check_field("byte_class", want.byte_class, out_ch.byte_class);
					check_field("header_complete", want.header_complete,
						out_ch.header_complete);
					check_field("headers_end", want.headers_end, out_ch.headers_end);
					check_field("request_done", want.request_done, out_ch.request_done);
					check_field("length_error", want.length_error, out_ch.length_error);
					check_field("body_length", want.body_length, out_ch.body_length);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_tags.insert(expected_tags.size(),
					tag_byte(in_ch.data_byte, in_ch.new_connection));
			waiting = expected_tags.size();
		end
	end

endmodule

/* tb/http_request_byte_parser_core_tb.sv */
// top of the http request byte parser bench: request stream, sink stalls, verdict
module http_request_byte_parser_core_tb;
	import hrbp_pkg::*;

	localparam int          ITEMS       = 1500;
	localparam int          CALM_AFTER  = 1300;
	localparam int          LIMIT       = 200000;
	localparam logic [63:0] LEN_MAX     = 64'h0000_0000_FFFF_FFFF;
	localparam int          BODY_CAP    = 48;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	hrbp_in_if  in_ch ();
	hrbp_out_if out_ch ();

	int fail_count;
	int open_tags;
	int cycles   = 0;
	int sent     = 0;
	bit calm     = 1'b0;
	bit quiet    = 1'b0;
	bit nc_next  = 1'b0;
	bit derailed = 1'b0;

	http_request_byte_parser_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	hrbp_tag_check tag_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_ch      (in_ch),
		.out_ch     (out_ch),
		.mismatches (fail_count),
		.pending    (open_tags)
	);

	initial forever #5 clk = ~clk;

	// hang guard
	initial begin
		while (cycles < LIMIT)
			@(posedge clk) cycles++;
		$display("status: fail");
		$finish;
	end

	// result sink with random stall bursts
	initial begin : sink
		int hold;
		hold = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (calm) begin
				out_ch.ready = 1'b1;
			end else if (hold > 0) begin
				out_ch.ready = 1'b0;
				hold--;
			end else if ($urandom_range(0, 4) == 0) begin
				out_ch.ready = 1'b0;
				hold = $urandom_range(0, 6);
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// one byte beat, entered and left at a falling edge
	task automatic put(input logic [7:0] b);
		if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
			in_ch.valid = 1'b0;
			repeat ($urandom_range(1, 7)) @(negedge clk);
		end
		in_ch.valid          = 1'b1;
		in_ch.data_byte      = b;
		in_ch.new_connection = nc_next;
		nc_next = 1'b0;
		do @(posedge clk); while (!in_ch.ready);
		sent++;
		calm = (sent >= CALM_AFTER);
		@(negedge clk);
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put(s[i]);
	endtask

	function automatic logic [7:0] pick_byte(input logic [7:0] not_a, input logic [7:0] not_b);
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (b == not_a || b == not_b);
		return b;
	endfunction

	task automatic put_letters();
		repeat ($urandom_range(1, 8))
			put(8'h61 + 8'($urandom_range(0, 25)));
	endtask

	// sender stops until every expected result has come back
	task automatic drain();
		in_ch.valid = 1'b0;
		while (open_tags != 0) @(negedge clk);
	endtask

	// one header line; a content-length key updates the body length
	task automatic send_header(inout longint unsigned eff);
		int               kind;
		int               form;
		int               n;
		longint unsigned  v;
		kind = $urandom_range(0, 9);
		n    = $urandom_range(0, 30);
		if (kind <= 5) begin
			put_text("Content-Length");
		end else if (kind == 6) begin
			case ($urandom_range(0, 4))
				0:       put_text("Content-Lengt");
				1:       put_text("Content-Lengthh");
				2:       put_text("content-length");
				3:       put_text("Content-Length ");
				default: put_text("XContent-Length");
			endcase
		end else if (kind == 7) begin
			put_letters();
		end else if (kind == 8) begin
			// key line that never reaches a colon
			put_letters();
			if ($urandom_range(0, 1)) put(CH_CR);
			put(CH_LF);
			return;
		end
		put(CH_COLON);
		repeat ($urandom_range(0, 2)) put(CH_SPACE);
		form = $urandom_range(0, 9);
		if (form <= 4) begin
			v = 64'(n);
			put_text($sformatf("%0d", n));
		end else if (form == 5) begin
			v = 64'(n);
			put_text({"00", $sformatf("%0d", n)});
		end else if (form == 6) begin
			v = ($urandom_range(0, 3) == 0) ? LEN_MAX : longint'($urandom);
			put_text($sformatf("%0d", v));
		end else if (form == 7) begin
			// overflow saturates
			v = LEN_MAX;
			if ($urandom_range(0, 1)) begin
				put_text("4294967296");
			end else begin
				put(8'h31 + 8'($urandom_range(0, 8)));
				repeat ($urandom_range(10, 12)) put(CH_ZERO + 8'($urandom_range(0, 9)));
			end
		end else if (form == 8) begin
			// value without leading digits
			v = 0;
			case ($urandom_range(0, 3))
				0:       ;
				1:       put_text("+7");
				2:       put_text("-3");
				default: put_text("x12");
			endcase
		end else begin
			v = 64'(n);
			put_text({$sformatf("%0d", n), " ab"});
		end
		if ($urandom_range(0, 1)) put(CH_CR);
		put(CH_LF);
		if (kind <= 5)
			eff = v;
	endtask

	// mostly well-formed request with random content
	task automatic send_request();
		longint unsigned eff;
		eff     = 0;
		quiet   = ($urandom_range(0, 3) == 0);
		nc_next = derailed || ($urandom_range(0, 7) == 0);
		derailed = 1'b0;
		repeat ($urandom_range(1, 4)) put(pick_byte(CH_SPACE, CH_SPACE));
		put(CH_SPACE);
		repeat ($urandom_range(1, 6)) put(pick_byte(CH_SPACE, CH_SPACE));
		put(CH_SPACE);
		repeat ($urandom_range(1, 4)) put(pick_byte(CH_SPACE, CH_LF));
		if ($urandom_range(0, 1)) put(CH_CR);
		put(CH_LF);
		repeat ($urandom_range(0, 4)) send_header(eff);
		if ($urandom_range(0, 1)) put(CH_CR);
		put(CH_LF);
		// body, cut short when the length is too long to send
		if (eff <= BODY_CAP) begin
			repeat (int'(eff)) put(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 20)) put(8'($urandom_range(0, 255)));
			derailed = 1'b1;
		end
	endtask

	// random bytes with random connection restarts
	task automatic send_noise();
		quiet = 1'b0;
		repeat ($urandom_range(1, 10)) begin
			nc_next = ($urandom_range(0, 3) == 0);
			put(8'($urandom_range(0, 255)));
		end
		derailed = 1'b1;
	endtask

	initial begin
		bit paused;
		paused               = 1'b0;
		in_ch.valid          = 1'b0;
		in_ch.data_byte      = '0;
		in_ch.new_connection = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: byte extremes, cr and lf before the path ends, lf in key,
		// empty key, skipped leading space, zero length completion, restarts
		nc_next = 1'b1;
		put(8'hFF);
		put(CH_CR);
		put(CH_LF);
		put(CH_SPACE);
		put(8'h00);
		put(CH_SPACE);
		put("H");
		put(CH_CR);
		put(CH_LF);
		put("k");
		put(CH_LF);
		put(CH_COLON);
		put(CH_SPACE);
		put("-");
		put(CH_LF);
		put(CH_CR);
		put(CH_LF);
		nc_next = 1'b1;
		put(CH_SPACE);
		nc_next = 1'b1;
		put("x");
		derailed = 1'b1;
		drain();

		// random requests and noise
		while (sent < ITEMS) begin
			if (!paused && sent >= ITEMS / 2) begin
				drain();
				paused = 1'b1;
			end
			if ($urandom_range(0, 9) == 0) send_noise();
			else send_request();
		end
		in_ch.valid = 1'b0;

		while (open_tags != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
